// ----- rtl/irl_pkg.sv -----
// shared types and constants of the ir range average linearizer
`default_nettype none

package irl_pkg;

  localparam int unsigned NCH        = 4;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [63:0]       SCALE_NUM = 64'd10000000000;
  localparam logic [DIST_W-1:0] DIST_SAT  = 16'hFFFF;
  localparam logic [DIST_W-1:0] DIST_NONE = 16'h0000;

  localparam logic [9:0]  AVG_LOW_RST  = 10'd90;
  localparam logic [9:0]  AVG_HIGH_RST = 10'd600;
  localparam logic [15:0] SLOPE_RST    = 16'd3318;
  localparam logic [19:0] OFFSET_RST   = 20'd28000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVG_LOW  = 2'd0,
    REG_AVG_HIGH = 2'd1,
    REG_SLOPE    = 2'd2,
    REG_OFFSET   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  avg_low;
    logic [9:0]  avg_high;
    logic [15:0] slope_coeff;
    logic [19:0] offset_coeff;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL,
    LN_DEN,
    LN_CHK,
    LN_DIV,
    LN_DONE
  } lane_state_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_t;

endpackage

`default_nettype wire

// ----- rtl/irl_lane.sv -----
// one channel lane: sample ring, running sum, range check and reciprocal divider
`default_nettype none

module irl_lane #(
  parameter int unsigned WINDOW   = 10,
  parameter int unsigned ADC_BITS = 10,
  parameter int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire irl_pkg::lane_ctrl_t           ctrl,
  input  wire logic [irl_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [SLOT_W-1:0]             slot,
  input  wire irl_pkg::cfg_t                 cfg,
  output irl_pkg::lane_stat_t                stat,
  output logic [irl_pkg::DIST_W-1:0]         distance
);

  localparam int unsigned SW       = irl_pkg::SAMPLE_W;
  localparam int unsigned WIN_BITS = $clog2(WINDOW + 1);
  localparam int unsigned SUM_MAX  = WINDOW * ((1 << SW) - 1);
  localparam int unsigned SUM_W    = $clog2(SUM_MAX + 1);
  localparam int unsigned LIM_W    = SW + WIN_BITS;
  localparam int unsigned PROD_W   = 16 + SUM_W;
  localparam int unsigned OFFS_W   = 20 + WIN_BITS;
  localparam int unsigned DEN_W    = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 1;
  localparam int unsigned REM_W    = DEN_W + 1;
  localparam logic [63:0] NUM_FULL = irl_pkg::SCALE_NUM * 64'(WINDOW);
  localparam int unsigned NUM_W    = $clog2(NUM_FULL + 64'd1);
  localparam int unsigned CMP_W    = (DEN_W + 16 > NUM_W) ? DEN_W + 16 : NUM_W;
  localparam logic [15:0] NUM_LO   = NUM_FULL[15:0];
  localparam logic [SW-1:0] SMP_MASK =
    (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);

  irl_pkg::lane_state_t state, state_next;

  logic [SW-1:0]     ring [WINDOW];
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic              in_rng;
  logic [DEN_W-1:0]  den;
  logic [REM_W-1:0]  rem;
  logic [3:0]        cnt;
  logic [15:0]       quot;

  logic [SW-1:0]    smp;
  logic [LIM_W-1:0] lim_lo;
  logic [LIM_W-1:0] lim_hi;
  logic             sat;
  logic [REM_W-1:0] shifted;
  logic             ge;

  assign smp     = sample & SMP_MASK;
  assign lim_lo  = LIM_W'(cfg.avg_low) * LIM_W'(WINDOW);
  assign lim_hi  = LIM_W'(cfg.avg_high) * LIM_W'(WINDOW);
  assign sat     = CMP_W'({den, 16'h0000}) <= CMP_W'(NUM_FULL);
  assign shifted = {rem[DEN_W-1:0], NUM_LO[cnt]};
  assign ge      = shifted >= REM_W'(den);

  always_comb begin
    state_next = state;
    case (state)
      irl_pkg::LN_IDLE: if (ctrl.start) state_next = irl_pkg::LN_MUL;
      irl_pkg::LN_MUL:  state_next = irl_pkg::LN_DEN;
      irl_pkg::LN_DEN:  state_next = irl_pkg::LN_CHK;
      irl_pkg::LN_CHK: begin
        if (!in_rng || sat) state_next = irl_pkg::LN_DONE;
        else state_next = irl_pkg::LN_DIV;
      end
      irl_pkg::LN_DIV:  if (cnt == 4'd0) state_next = irl_pkg::LN_DONE;
      irl_pkg::LN_DONE: if (ctrl.ack) state_next = irl_pkg::LN_IDLE;
      default:          state_next = irl_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != irl_pkg::LN_IDLE);
    stat.done = (state == irl_pkg::LN_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irl_pkg::LN_IDLE;
      sum   <= '0;
      for (int i = 0; i < WINDOW; i++) ring[i] <= '0;
    end else begin
      state <= state_next;
      if (state == irl_pkg::LN_IDLE && ctrl.start) begin
        ring[slot] <= smp;
        sum        <= sum - SUM_W'(ring[slot]) + SUM_W'(smp);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      irl_pkg::LN_MUL: begin
        prod   <= PROD_W'(cfg.slope_coeff) * PROD_W'(sum);
        in_rng <= (LIM_W'(sum) > lim_lo) && (LIM_W'(sum) < lim_hi);
      end
      irl_pkg::LN_DEN: begin
        den <= DEN_W'(prod) + DEN_W'(OFFS_W'(cfg.offset_coeff) * OFFS_W'(WINDOW));
      end
      irl_pkg::LN_CHK: begin
        rem <= REM_W'(NUM_FULL >> 16);
        cnt <= 4'd15;
        if (!in_rng) quot <= irl_pkg::DIST_NONE;
        else if (sat) quot <= irl_pkg::DIST_SAT;
        else quot <= '0;
      end
      irl_pkg::LN_DIV: begin
        rem  <= ge ? shifted - REM_W'(den) : shifted;
        quot <= {quot[14:0], ge};
        cnt  <= cnt - 4'd1;
      end
      default: ;
    endcase
  end

  assign distance = quot;

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sum) <= SUM_MAX)
    else $error("running sum above window maximum");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (state == irl_pkg::LN_DONE && !in_rng) |-> (quot == irl_pkg::DIST_NONE))
    else $error("out of range channel gives nonzero distance");

  a_div_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == irl_pkg::LN_DIV) |-> (rem < REM_W'(den)))
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/ir_range_avg_linearizer_core.sv -----
// top level: config registers, slot counter, four lanes and merged output word
//
// usage
//   input channel: in_valid / in_stall with sample_a..sample_d, one word per
//   scan of the four sensors. output channel: out_valid / out_stall with
//   dist_a..dist_d, one word per input word, in order.
//   config port: cfg_we, cfg_index, cfg_data; write only while idle.
// processing
//   the four lanes run side by side; each lane updates its ring and sum on
//   the accepting edge, then does one multiply with the range check, one add
//   and the saturation check, then runs a shift-subtract divider.
//   a lane whose channel is out of range or saturated skips the divider;
//   out_valid rises once all four lanes are done. the next word can only be
//   accepted in the cycle after the output word is loaded, not before.
// reset
//   rings, sums and slot clear at once, config takes its default values;
//   no clearing pass is needed.
// stall
//   a finished word waits in the output register while the next word is
//   accepted and computed; lanes hold their result until it is free.
`default_nettype none

module ir_range_avg_linearizer_core #(
  parameter int unsigned WINDOW   = 10,
  parameter int unsigned ADC_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [irl_pkg::SAMPLE_W-1:0]     sample_a,
  input  wire logic [irl_pkg::SAMPLE_W-1:0]     sample_b,
  input  wire logic [irl_pkg::SAMPLE_W-1:0]     sample_c,
  input  wire logic [irl_pkg::SAMPLE_W-1:0]     sample_d,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [irl_pkg::DIST_W-1:0]            dist_a,
  output logic [irl_pkg::DIST_W-1:0]            dist_b,
  output logic [irl_pkg::DIST_W-1:0]            dist_c,
  output logic [irl_pkg::DIST_W-1:0]            dist_d,
  input  wire logic                             cfg_we,
  input  wire logic [irl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [irl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NCH    = irl_pkg::NCH;
  localparam int unsigned DW     = irl_pkg::DIST_W;

  irl_pkg::top_state_t state, state_next;
  irl_pkg::cfg_t       cfg;
  irl_pkg::lane_ctrl_t ctrl;
  irl_pkg::lane_stat_t stat [NCH];

  logic [SLOT_W-1:0]             slot;
  logic [irl_pkg::SAMPLE_W-1:0]  smp  [NCH];
  logic [DW-1:0]                 ldist [NCH];
  logic [DW-1:0]                 obuf [NCH];
  logic [NCH-1:0]                done_vec;
  logic [NCH-1:0]                busy_vec;
  logic                          accept;
  logic                          all_done;
  logic                          load;

  assign smp[0] = sample_a;
  assign smp[1] = sample_b;
  assign smp[2] = sample_c;
  assign smp[3] = sample_d;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    irl_lane #(
      .WINDOW   (WINDOW),
      .ADC_BITS (ADC_BITS),
      .SLOT_W   (SLOT_W)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (smp[c]),
      .slot     (slot),
      .cfg      (cfg),
      .stat     (stat[c]),
      .distance (ldist[c])
    );
    assign done_vec[c] = stat[c].done;
    assign busy_vec[c] = stat[c].busy;
  end

  assign all_done = &done_vec;
  assign accept   = in_valid && !in_stall;
  assign load     = (state == irl_pkg::TOP_BUSY) && all_done && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      irl_pkg::TOP_IDLE: if (accept) state_next = irl_pkg::TOP_BUSY;
      irl_pkg::TOP_BUSY: if (load) state_next = irl_pkg::TOP_IDLE;
      default:           state_next = irl_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != irl_pkg::TOP_IDLE);
    ctrl.start = accept;
    ctrl.ack   = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irl_pkg::TOP_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (slot == SLOT_W'(WINDOW - 1)) slot <= '0;
        else slot <= slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.avg_low      <= irl_pkg::AVG_LOW_RST;
      cfg.avg_high     <= irl_pkg::AVG_HIGH_RST;
      cfg.slope_coeff  <= irl_pkg::SLOPE_RST;
      cfg.offset_coeff <= irl_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irl_pkg::REG_AVG_LOW:  cfg.avg_low      <= cfg_data[9:0];
        irl_pkg::REG_AVG_HIGH: cfg.avg_high     <= cfg_data[9:0];
        irl_pkg::REG_SLOPE:    cfg.slope_coeff  <= cfg_data[15:0];
        irl_pkg::REG_OFFSET:   cfg.offset_coeff <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // merge the four lane results into one output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < NCH; c++) obuf[c] <= ldist[c];
    end
  end

  assign dist_a = obuf[0];
  assign dist_b = obuf[1];
  assign dist_c = obuf[2];
  assign dist_d = obuf[3];

`ifndef SYNTHESIS
  a_load_needs_lanes: assert property (@(posedge clk) disable iff (rst)
    load |-> (busy_vec == {NCH{1'b1}}))
    else $error("output loaded while a lane is idle");

  a_idle_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == irl_pkg::TOP_IDLE) |-> (busy_vec == '0))
    else $error("lane busy while top is idle");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slot) < WINDOW)
    else $error("write slot beyond window");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (busy_vec == {NCH{1'b1}}))
    else $error("lanes did not all start on acceptance");
`endif

endmodule

`default_nettype wire
